@@ src/qpid_pkg.sv @@
// Shared types, widths, codes and reset values of the quadrature PID position controller.
`default_nettype none

package qpid_pkg;

  // Fixed field and state widths
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned GOAL_W     = 16;
  localparam int unsigned CPR_W      = 16;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned REF_W      = 33;
  localparam int unsigned ERR_W      = 34;
  localparam int unsigned GOAL_EXT_W = GOAL_W + 1;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned MAC_TERMS  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Parameter defaults
  localparam int unsigned IW_DEFAULT       = 48;
  localparam int unsigned DUTY_MAX_DEFAULT = 100;

  // Reset values
  localparam logic [GAIN_W-1:0] KP_RESET  = 32'd3106891;
  localparam logic [GAIN_W-1:0] KI_RESET  = 32'd117;
  localparam logic [GAIN_W-1:0] KD_RESET  = 32'd15534459;
  localparam logic [CPR_W-1:0]  CPR_RESET = 16'd216;
  localparam logic [REF_W-1:0]  REF_RESET = 33'd2160;

  // Input commands
  typedef enum logic [1:0] {
    CMD_EDGE_A = 2'd0,
    CMD_EDGE_B = 2'd1,
    CMD_PULSE  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_GOAL1 = 3'd3,
    REG_GOAL2 = 3'd4,
    REG_CPR   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic signed [GOAL_W-1:0] goal1;
    logic signed [GOAL_W-1:0] goal2;
    logic [CPR_W-1:0]         cpr;
  } cfg_t;

  typedef struct packed {
    cmd_e command;
    logic enc_a;
    logic enc_b;
    logic pulse_level;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       forward_duty;
    logic [DUTY_W-1:0]       reverse_duty;
    logic signed [POS_W-1:0] position_count;
    logic [PHASE_W-1:0]      goal_phase;
  } out_t;

endpackage

`default_nettype wire

@@ src/qpid_cfg.sv @@
// Configuration register bank: gains, goals and counts per revolution.
`default_nettype none

module qpid_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [qpid_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [qpid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output qpid_pkg::cfg_t                      cfg_o
);
  import qpid_pkg::*;

  cfg_t cfg_q;

  // Decode the index and update one register per write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp    <= KP_RESET;
      cfg_q.ki    <= KI_RESET;
      cfg_q.kd    <= KD_RESET;
      cfg_q.goal1 <= '0;
      cfg_q.goal2 <= '0;
      cfg_q.cpr   <= CPR_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_KP:    cfg_q.kp    <= cfg_data_i[GAIN_W-1:0];
        REG_KI:    cfg_q.ki    <= cfg_data_i[GAIN_W-1:0];
        REG_KD:    cfg_q.kd    <= cfg_data_i[GAIN_W-1:0];
        REG_GOAL1: cfg_q.goal1 <= cfg_data_i[GOAL_W-1:0];
        REG_GOAL2: cfg_q.goal2 <= cfg_data_i[GOAL_W-1:0];
        REG_CPR:   cfg_q.cpr   <= cfg_data_i[CPR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ src/qpid_mac.sv @@
// Bit-serial multiply-accumulate: sum of three signed values times unsigned gains.
`default_nettype none

module qpid_mac #(
  parameter int unsigned VW = qpid_pkg::IW_DEFAULT
) (
  input  wire logic                                                 clk_i,
  input  wire logic                                                 rst_ni,
  input  wire logic                                                 start_i,
  input  wire logic [qpid_pkg::MAC_TERMS-1:0][VW-1:0]               value_i,
  input  wire logic [qpid_pkg::MAC_TERMS-1:0][qpid_pkg::GAIN_W-1:0] gain_i,
  output logic                                                      done_o,
  output logic [VW+qpid_pkg::GAIN_W+1:0]                            sum_o
);
  import qpid_pkg::*;

  localparam int unsigned AW = VW + 2;
  localparam int unsigned CW = $clog2(GAIN_W);

  logic [MAC_TERMS-1:0][VW-1:0]     val_q;
  logic [MAC_TERMS-1:0][GAIN_W-1:0] gain_q;
  logic [AW-1:0]                    acc_q;
  logic [GAIN_W-1:0]                low_q;
  logic [CW-1:0]                    cnt_q;
  logic                             busy_q;
  logic                             done_q;
  logic [AW:0]                      step_sum;

  // Add every value whose gain bit is set this cycle to the running high part
  always_comb begin
    step_sum = {acc_q[AW-1], acc_q};
    for (int i = 0; i < MAC_TERMS; i++) begin
      if (gain_q[i][0]) begin
        step_sum = step_sum + {{3{val_q[i][VW-1]}}, val_q[i]};
      end
    end
  end

  // Sequence one gain bit per cycle, LSB first; shift finished low bits out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      val_q  <= '0;
      gain_q <= '0;
      acc_q  <= '0;
      low_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        val_q  <= value_i;
        gain_q <= gain_i;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= step_sum[AW:1];
        low_q <= {step_sum[0], low_q[GAIN_W-1:1]};
        for (int i = 0; i < MAC_TERMS; i++) begin
          gain_q[i] <= gain_q[i] >> 1;
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(GAIN_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = {acc_q, low_q};

endmodule

`default_nettype wire

@@ src/quadrature_pid_position_control.sv @@
// Top level: quadrature decoding, PID state, goal sequencing and duty output register.
//
// Input beats carry a command: an edge on encoder channel A or B, a goal pulse
// sample, or a control tick. Edges move the position count, then register the
// error, then update integral and derivative; they give no result. A pulse
// sample gives no result. A control tick in goal phase 1 or 2 gives one output
// beat with both duties, the position and the phase. It runs the shared
// bit-serial multiply-accumulate unit twice, over 32 gain bits each time:
// first for the reference product, then, after the error is registered, for
// the PID sum; the duty is then clamped and loaded into the output register.
// A tick in any other phase gives nothing.
// in_stall_o is high while an item is being worked on. The result sits in an
// output register; while the receiver stalls it, edges and pulse samples are
// still taken, and only a following tick waits for the register to free up.
// Configuration writes are taken at any cycle and are meant for idle periods.
// Reset loads the default gains, a reference of 2160 counts, phase zero and
// clears position, integral and derivative.
`default_nettype none

module quadrature_pid_position_control #(
  parameter int unsigned INTEGRAL_WIDTH = qpid_pkg::IW_DEFAULT,
  parameter int unsigned DUTY_MAX       = qpid_pkg::DUTY_MAX_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [qpid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [qpid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire qpid_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output qpid_pkg::out_t                       out_data_o
);
  import qpid_pkg::*;

  localparam int unsigned IW = INTEGRAL_WIDTH;
  localparam int unsigned SW = IW + GAIN_W + 2;
  localparam int unsigned MW = SW - FRAC_W;
  localparam int unsigned DW = $clog2(DUTY_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR_EDGE,
    S_INTEG,
    S_REF,
    S_ERR_TICK,
    S_PID,
    S_DUTY
  } state_e;

  state_e             state_q;
  cfg_t               cfg;
  logic [POS_W-1:0]   position_q;
  logic [REF_W-1:0]   reference_q;
  logic [ERR_W-1:0]   err_q;
  logic [ERR_W-1:0]   prev_err_q;
  logic [ERR_W-1:0]   deriv_q;
  logic [IW-1:0]      integ_q;
  logic               pulse_prev_q;
  logic [PHASE_W-1:0] pulse_cnt_q;
  logic               neg_q;
  logic [MW-1:0]      mag_q;
  logic               out_valid_q;
  out_t               out_q;

  logic                             in_accept;
  logic                             phase_ok;
  logic [GOAL_EXT_W-1:0]            goal_calc;
  logic [ERR_W-1:0]                 err_calc;
  logic [IW:0]                      integ_sum;
  logic [IW-1:0]                    integ_next;
  logic [MAC_TERMS-1:0][IW-1:0]     mac_value;
  logic [MAC_TERMS-1:0][GAIN_W-1:0] mac_gain;
  logic                             mac_start;
  logic                             mac_done;
  logic [SW-1:0]                    mac_sum;
  logic [MW-1:0]                    mag_calc;
  logic [DW-1:0]                    duty_calc;
  logic                             err_pos;
  logic                             out_free;
  logic                             out_load;

  qpid_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign phase_ok   = (pulse_cnt_q == 2'd1) || (pulse_cnt_q == 2'd2);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DUTY) && out_free;

  // Active goal in revolutions; the second goal is applied negated
  assign goal_calc = (pulse_cnt_q == 2'd1) ? {cfg.goal1[GOAL_W-1], cfg.goal1}
                                           : -{cfg.goal2[GOAL_W-1], cfg.goal2};

  // Error in counts: reference minus position
  assign err_calc = {reference_q[REF_W-1], reference_q}
                  - {{(ERR_W - POS_W){position_q[POS_W-1]}}, position_q};

  // Saturating integral update
  assign integ_sum = {integ_q[IW-1], integ_q} + {{(IW + 1 - ERR_W){err_q[ERR_W-1]}}, err_q};
  always_comb begin
    if (integ_sum[IW] != integ_sum[IW-1]) begin
      integ_next = integ_sum[IW] ? {1'b1, {(IW - 1){1'b0}}} : {1'b0, {(IW - 1){1'b1}}};
    end else begin
      integ_next = integ_sum[IW-1:0];
    end
  end

  // Feed the serial unit: goal times counts per revolution, then the PID terms
  always_comb begin
    if (state_q == S_IDLE) begin
      mac_value[0] = {{(IW - GOAL_EXT_W){goal_calc[GOAL_EXT_W-1]}}, goal_calc};
      mac_value[1] = '0;
      mac_value[2] = '0;
      mac_gain[0]  = {{(GAIN_W - CPR_W){1'b0}}, cfg.cpr};
      mac_gain[1]  = '0;
      mac_gain[2]  = '0;
    end else begin
      mac_value[0] = {{(IW - ERR_W){err_calc[ERR_W-1]}}, err_calc};
      mac_value[1] = integ_q;
      mac_value[2] = {{(IW - ERR_W){deriv_q[ERR_W-1]}}, deriv_q};
      mac_gain[0]  = cfg.kp;
      mac_gain[1]  = cfg.ki;
      mac_gain[2]  = cfg.kd;
    end
  end

  assign mac_start = (in_accept && (in_data_i.command == CMD_TICK) && phase_ok)
                   || (state_q == S_ERR_TICK);

  qpid_mac #(
    .VW (IW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .value_i (mac_value),
    .gain_i  (mac_gain),
    .done_o  (mac_done),
    .sum_o   (mac_sum)
  );

  // Magnitude of the sum shifted down, truncated toward zero
  assign mag_calc = mac_sum[SW-1] ? (~mac_sum[SW-1:FRAC_W] + MW'(mac_sum[FRAC_W-1:0] == '0))
                                  : mac_sum[SW-1:FRAC_W];

  // Clamp the duty and pick the drive direction
  assign duty_calc = (mag_q > MW'(DUTY_MAX)) ? DW'(DUTY_MAX) : mag_q[DW-1:0];
  assign err_pos   = !err_q[ERR_W-1] && (err_q != '0);

  // Sequence commands, hold PID state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      position_q   <= '0;
      reference_q  <= REF_RESET;
      err_q        <= '0;
      prev_err_q   <= '0;
      deriv_q      <= '0;
      integ_q      <= '0;
      pulse_prev_q <= 1'b0;
      pulse_cnt_q  <= '0;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      // Load a new drive beat, or drop the one taken by the receiver
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            unique case (in_data_i.command)
              CMD_EDGE_A: begin
                position_q <= (in_data_i.enc_a != in_data_i.enc_b) ? position_q + 1'b1
                                                                   : position_q - 1'b1;
                state_q    <= S_ERR_EDGE;
              end
              CMD_EDGE_B: begin
                position_q <= (in_data_i.enc_a == in_data_i.enc_b) ? position_q + 1'b1
                                                                   : position_q - 1'b1;
                state_q    <= S_ERR_EDGE;
              end
              CMD_PULSE: begin
                if (!pulse_prev_q && in_data_i.pulse_level) begin
                  if (pulse_cnt_q != 2'd3) begin
                    pulse_cnt_q <= pulse_cnt_q + 1'b1;
                  end
                  integ_q <= '0;
                end
                pulse_prev_q <= in_data_i.pulse_level;
              end
              CMD_TICK: begin
                if (phase_ok) begin
                  state_q <= S_REF;
                end
              end
              default: ;
            endcase
          end
        end
        S_ERR_EDGE: begin
          err_q   <= err_calc;
          state_q <= S_INTEG;
        end
        S_INTEG: begin
          integ_q    <= integ_next;
          deriv_q    <= prev_err_q - err_q;
          prev_err_q <= err_q;
          state_q    <= S_IDLE;
        end
        S_REF: begin
          if (mac_done) begin
            reference_q <= mac_sum[REF_W-1:0];
            state_q     <= S_ERR_TICK;
          end
        end
        S_ERR_TICK: begin
          err_q   <= err_calc;
          state_q <= S_PID;
        end
        S_PID: begin
          if (mac_done) begin
            neg_q   <= mac_sum[SW-1];
            mag_q   <= mag_calc;
            state_q <= S_DUTY;
          end
        end
        S_DUTY: begin
          if (out_free) begin
            out_q.forward_duty   <= (err_pos && !neg_q) ? DUTY_W'(duty_calc) : '0;
            out_q.reverse_duty   <= (!err_pos && neg_q) ? DUTY_W'(duty_calc) : '0;
            out_q.position_count <= position_q;
            out_q.goal_phase     <= pulse_cnt_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result only comes from an active goal phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.goal_phase == 2'd1 || out_data_o.goal_phase == 2'd2))
    else $error("result with inactive goal phase");

  // Only one bridge side is ever driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.forward_duty == '0 || out_data_o.reverse_duty == '0))
    else $error("both duties nonzero");

  // The serial unit finishes only while a tick waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == S_REF || state_q == S_PID))
    else $error("serial unit finished outside a tick");

endmodule

`default_nettype wire
